// ----- rtl/srf_pkg.sv -----
// Shared types and constants of the serial request framer.
`timescale 1ns / 1ps
package srf_pkg;

  // Input opcodes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_RX_BYTE = 2'd2;
  localparam logic [1:0] OP_TIMEOUT = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_LINK_BYTE = 3'd0;
  localparam logic [2:0] KIND_RESP_BYTE = 3'd1;
  localparam logic [2:0] KIND_DONE_OK   = 3'd2;
  localparam logic [2:0] KIND_DONE_FAIL = 3'd3;
  localparam logic [2:0] KIND_REJECTED  = 3'd4;

  // Link constants
  localparam logic [7:0] SYNC_BYTE  = 8'h5A;
  localparam logic [7:0] ACK_BYTE   = 8'h79;
  localparam logic [7:0] CHECK_SEED = 8'hAB;
  localparam int unsigned HEADER_BYTES = 7;

  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Job types handed from front to back
  typedef enum logic [1:0] {
    JOB_HEADER = 2'd0,
    JOB_SINGLE = 2'd1,
    JOB_PAIR   = 2'd2
  } job_type_e;

  // One job: header uses b0 = endpoint, b1 = header check, len = tx length,
  // mr = response limit. Pair sends b0 then b1. Single sends kind/b0/len.
  typedef struct packed {
    job_type_e   jtype;
    logic [2:0]  kind;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] len;
    logic [15:0] mr;
  } job_t;

  // Queue status toward the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } queue_head_t;

endpackage

// ----- rtl/srf_front.sv -----
// Front end: accepts items, tracks the transaction phase and emits jobs.
`timescale 1ns / 1ps
module srf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         endpoint_i,
  input  logic [15:0]        tx_length_i,
  input  logic [15:0]        max_response_i,
  input  logic [7:0]         data_byte_i,
  input  logic               q_full_i,
  output logic               push_o,
  output srf_pkg::job_t      job_o
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_WAIT_ACK = 3'd1;
  localparam logic [2:0] PH_PAYLOAD  = 3'd2;
  localparam logic [2:0] PH_RESP_ACK = 3'd3;
  localparam logic [2:0] PH_LEN_LO   = 3'd4;
  localparam logic [2:0] PH_LEN_HI   = 3'd5;
  localparam logic [2:0] PH_DATA     = 3'd6;
  localparam logic [2:0] PH_CHECK    = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] tx_left_q, tx_left_d;
  logic [7:0]  run_check_q, run_check_d;
  logic [15:0] resp_limit_q, resp_limit_d;
  logic [15:0] resp_left_q, resp_left_d;
  logic [15:0] resp_count_q, resp_count_d;
  logic [7:0]  len_low_q, len_low_d;

  logic        accept;
  logic        emit;
  logic [7:0]  new_check;
  logic [15:0] tx_dec;
  logic [15:0] rx_len;
  logic [15:0] clamped;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && emit;

  assign new_check = run_check_q ^ data_byte_i;
  assign tx_dec    = tx_left_q - 16'd1;
  assign rx_len    = {data_byte_i, len_low_q};
  assign clamped   = (rx_len > resp_limit_q) ? resp_limit_q : rx_len;

  always_comb begin
    phase_d      = phase_q;
    tx_left_d    = tx_left_q;
    run_check_d  = run_check_q;
    resp_limit_d = resp_limit_q;
    resp_left_d  = resp_left_q;
    resp_count_d = resp_count_q;
    len_low_d    = len_low_q;
    emit         = 1'b1;
    job_o.jtype  = srf_pkg::JOB_SINGLE;
    job_o.kind   = srf_pkg::KIND_REJECTED;
    job_o.b0     = 8'd0;
    job_o.b1     = 8'd0;
    job_o.len    = 16'd0;
    job_o.mr     = 16'd0;

    case (opcode_i)
      srf_pkg::OP_START: begin
        if (phase_q == PH_IDLE) begin
          job_o.jtype  = srf_pkg::JOB_HEADER;
          job_o.kind   = srf_pkg::KIND_LINK_BYTE;
          job_o.b0     = endpoint_i;
          job_o.b1     = srf_pkg::CHECK_SEED ^ srf_pkg::SYNC_BYTE ^ endpoint_i
                         ^ tx_length_i[7:0] ^ tx_length_i[15:8]
                         ^ max_response_i[7:0] ^ max_response_i[15:8];
          job_o.len    = tx_length_i;
          job_o.mr     = max_response_i;
          tx_left_d    = tx_length_i;
          resp_limit_d = max_response_i;
          run_check_d  = srf_pkg::CHECK_SEED;
          resp_left_d  = 16'd0;
          resp_count_d = 16'd0;
          len_low_d    = 8'd0;
          phase_d      = PH_WAIT_ACK;
        end
      end
      srf_pkg::OP_PAYLOAD: begin
        if (phase_q == PH_PAYLOAD) begin
          job_o.kind  = srf_pkg::KIND_LINK_BYTE;
          job_o.b0    = data_byte_i;
          job_o.b1    = new_check;
          run_check_d = new_check;
          tx_left_d   = tx_dec;
          // last payload byte: append the running check
          if (tx_dec == 16'd0) begin
            job_o.jtype = srf_pkg::JOB_PAIR;
            phase_d     = PH_RESP_ACK;
          end
        end
      end
      srf_pkg::OP_TIMEOUT: begin
        if (phase_q != PH_IDLE) begin
          phase_d = PH_IDLE;
          if (phase_q == PH_CHECK) begin
            job_o.kind = srf_pkg::KIND_DONE_OK;
            job_o.len  = resp_count_q;
          end else begin
            job_o.kind = srf_pkg::KIND_DONE_FAIL;
          end
        end
      end
      default: begin
        case (phase_q)
          PH_WAIT_ACK: begin
            if (data_byte_i != srf_pkg::ACK_BYTE) begin
              job_o.kind = srf_pkg::KIND_DONE_FAIL;
              phase_d    = PH_IDLE;
            end else begin
              emit    = 1'b0;
              phase_d = (tx_left_q != 16'd0) ? PH_PAYLOAD : PH_RESP_ACK;
            end
          end
          PH_RESP_ACK: begin
            if (data_byte_i != srf_pkg::ACK_BYTE) begin
              job_o.kind = srf_pkg::KIND_DONE_FAIL;
              phase_d    = PH_IDLE;
            end else begin
              emit    = 1'b0;
              phase_d = PH_LEN_LO;
            end
          end
          PH_LEN_LO: begin
            emit      = 1'b0;
            len_low_d = data_byte_i;
            phase_d   = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            emit         = 1'b0;
            resp_left_d  = clamped;
            resp_count_d = clamped;
            phase_d      = (clamped != 16'd0) ? PH_DATA : PH_CHECK;
          end
          PH_DATA: begin
            job_o.kind  = srf_pkg::KIND_RESP_BYTE;
            job_o.b0    = data_byte_i;
            resp_left_d = resp_left_q - 16'd1;
            if (resp_left_d == 16'd0) begin
              phase_d = PH_CHECK;
            end
          end
          PH_CHECK: begin
            // trailing check byte is consumed unchecked
            job_o.kind = srf_pkg::KIND_DONE_OK;
            job_o.len  = resp_count_q;
            phase_d    = PH_IDLE;
          end
          default: begin
            job_o.kind = srf_pkg::KIND_REJECTED;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      tx_left_q    <= 16'd0;
      run_check_q  <= srf_pkg::CHECK_SEED;
      resp_limit_q <= 16'd0;
      resp_left_q  <= 16'd0;
      resp_count_q <= 16'd0;
      len_low_q    <= 8'd0;
    end else if (accept) begin
      phase_q      <= phase_d;
      tx_left_q    <= tx_left_d;
      run_check_q  <= run_check_d;
      resp_limit_q <= resp_limit_d;
      resp_left_q  <= resp_left_d;
      resp_count_q <= resp_count_d;
      len_low_q    <= len_low_d;
    end
  end

endmodule

// ----- rtl/srf_queue.sv -----
// Job queue between the front and back ends.
`timescale 1ns / 1ps
module srf_queue #(
  parameter int unsigned Depth = srf_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  srf_pkg::job_t        job_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output srf_pkg::queue_head_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  srf_pkg::job_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.job   = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/srf_back.sv -----
// Back end: expands queued jobs into result items through an output register.
`timescale 1ns / 1ps
module srf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srf_pkg::queue_head_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           out_kind_o,
  output logic [7:0]           out_byte_o,
  output logic [15:0]          resp_length_o,
  output logic                 last_o
);

  localparam int unsigned IdxW = $clog2(srf_pkg::HEADER_BYTES);

  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] last_idx;
  logic            load;
  logic            is_last;
  logic [7:0]      sel_byte;
  logic            out_valid_q;
  logic [2:0]      kind_q;
  logic [7:0]      byte_q;
  logic [15:0]     len_q;
  logic            last_q;

  always_comb begin
    case (head_i.job.jtype)
      srf_pkg::JOB_HEADER: last_idx = IdxW'(srf_pkg::HEADER_BYTES - 1);
      srf_pkg::JOB_PAIR:   last_idx = IdxW'(1);
      default:             last_idx = '0;
    endcase
  end

  always_comb begin
    if (head_i.job.jtype == srf_pkg::JOB_HEADER) begin
      case (idx_q)
        IdxW'(0): sel_byte = srf_pkg::SYNC_BYTE;
        IdxW'(1): sel_byte = head_i.job.b0;
        IdxW'(2): sel_byte = head_i.job.len[7:0];
        IdxW'(3): sel_byte = head_i.job.len[15:8];
        IdxW'(4): sel_byte = head_i.job.mr[7:0];
        IdxW'(5): sel_byte = head_i.job.mr[15:8];
        default:  sel_byte = head_i.job.b1;
      endcase
    end else if (idx_q != '0) begin
      sel_byte = head_i.job.b1;
    end else begin
      sel_byte = head_i.job.b0;
    end
  end

  assign load    = head_i.valid && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == last_idx);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the payload while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= head_i.job.kind;
      byte_q <= sel_byte;
      len_q  <= (head_i.job.jtype == srf_pkg::JOB_SINGLE) ? head_i.job.len : 16'd0;
      last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = kind_q;
  assign out_byte_o    = byte_q;
  assign resp_length_o = len_q;
  assign last_o        = last_q;

endmodule

// ----- rtl/serial_request_framer.sv -----
// Top level of the serial request framer.
//
// Usage: items enter on the in channel (valid/ready), results leave on the
// out channel (valid/ready). A start item yields seven link bytes (sync,
// endpoint, transmit length, response limit, header check); payload bytes
// are echoed to the link with the running check after the last one; link
// bytes are parsed into acknowledge, length, response data and check.
// Path: the first result of an item passes through the job queue and then
// the output register. Throughput: one item per cycle is taken while the job
// queue (QueueDepth jobs) has room; the output delivers one result per cycle
// while the receiver is ready: the seven link bytes of a start item, a last
// payload byte and its check, and one result for other items. Items that
// cause no result still take an input transfer but push no job.
// Reset: the phase returns to idle, the queue and output register empty.
// When the receiver stalls, the output holds its result, the queue fills,
// and in_ready_o drops once it is full.
`timescale 1ns / 1ps
module serial_request_framer #(
  parameter int unsigned QueueDepth = srf_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  endpoint_i,
  input  logic [15:0] tx_length_i,
  input  logic [15:0] max_response_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] resp_length_o,
  output logic        last_o
);

  logic                 q_full;
  logic                 push;
  logic                 pop;
  srf_pkg::job_t        job;
  srf_pkg::queue_head_t head;

  srf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .endpoint_i     (endpoint_i),
    .tx_length_i    (tx_length_i),
    .max_response_i (max_response_i),
    .data_byte_i    (data_byte_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .job_o          (job)
  );

  srf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  srf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_kind_o    (out_kind_o),
    .out_byte_o    (out_byte_o),
    .resp_length_o (resp_length_o),
    .last_o        (last_o)
  );

endmodule

// ----- bench/serial_request_framer_test.sv -----
// Self-checking bench for the serial request framer: directed and random link traffic.
`timescale 1ns / 1ps
module serial_request_framer_test;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT_ACK, PH_PAYLOAD, PH_RESP_ACK, PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_CHECK
  } link_phase_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_val;
    logic [15:0] length;
    logic        last;
  } link_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  opcode_i;
  logic [7:0]  endpoint_i;
  logic [15:0] tx_length_i;
  logic [15:0] max_response_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  out_kind_o;
  logic [7:0]  out_byte_o;
  logic [15:0] resp_length_o;
  logic        last_o;

  // Transaction tracker state, updated on every input transfer
  link_phase_e phase_q       = PH_IDLE;
  logic [15:0] tx_left_q     = '0;
  logic [7:0]  run_check_q   = srf_pkg::CHECK_SEED;
  logic [15:0] resp_limit_q  = '0;
  logic [15:0] resp_left_q   = '0;
  logic [15:0] resp_count_q  = '0;
  logic [7:0]  len_low_q     = '0;

  link_result_t pending_results[$];
  int mismatches = 0;
  int src_idle_pct = 0;
  int stall_pct = 0;
  int stall_burst = 0;

  serial_request_framer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .endpoint_i     (endpoint_i),
    .tx_length_i    (tx_length_i),
    .max_response_i (max_response_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .resp_length_o  (resp_length_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Append one expected result to the tail of the pending list.
  function automatic void add_result(logic [2:0] kind, logic [7:0] byte_val,
                                     logic [15:0] length);
    link_result_t r;
    r.kind     = kind;
    r.byte_val = byte_val;
    r.length   = length;
    r.last     = 1'b0;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Advance the tracker by one item and queue the link results it causes.
  function automatic void frame_item(logic [1:0] op, logic [7:0] ep, logic [15:0] tl,
                                     logic [15:0] mr, logic [7:0] b);
    logic [7:0]   hdr_check;
    logic [15:0]  rlen;
    bit           rejected;
    int           first;
    rejected = 1'b0;
    first    = pending_results.size();
    case (op)
      srf_pkg::OP_START: begin
        if (phase_q != PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          hdr_check = srf_pkg::CHECK_SEED ^ srf_pkg::SYNC_BYTE ^ ep ^ tl[7:0] ^ tl[15:8]
                      ^ mr[7:0] ^ mr[15:8];
          add_result(srf_pkg::KIND_LINK_BYTE, srf_pkg::SYNC_BYTE, 16'd0);
          add_result(srf_pkg::KIND_LINK_BYTE, ep, 16'd0);
          add_result(srf_pkg::KIND_LINK_BYTE, tl[7:0], 16'd0);
          add_result(srf_pkg::KIND_LINK_BYTE, tl[15:8], 16'd0);
          add_result(srf_pkg::KIND_LINK_BYTE, mr[7:0], 16'd0);
          add_result(srf_pkg::KIND_LINK_BYTE, mr[15:8], 16'd0);
          add_result(srf_pkg::KIND_LINK_BYTE, hdr_check, 16'd0);
          tx_left_q    = tl;
          resp_limit_q = mr;
          run_check_q  = srf_pkg::CHECK_SEED;
          resp_left_q  = '0;
          resp_count_q = '0;
          len_low_q    = '0;
          phase_q      = PH_WAIT_ACK;
        end
      end
      srf_pkg::OP_PAYLOAD: begin
        if (phase_q != PH_PAYLOAD) begin
          rejected = 1'b1;
        end else begin
          add_result(srf_pkg::KIND_LINK_BYTE, b, 16'd0);
          run_check_q = run_check_q ^ b;
          tx_left_q   = tx_left_q - 16'd1;
          if (tx_left_q == 16'd0) begin
            add_result(srf_pkg::KIND_LINK_BYTE, run_check_q, 16'd0);
            phase_q = PH_RESP_ACK;
          end
        end
      end
      srf_pkg::OP_TIMEOUT: begin
        if (phase_q == PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          // a missing trailing check byte still counts as success
          if (phase_q == PH_CHECK) add_result(srf_pkg::KIND_DONE_OK, 8'd0, resp_count_q);
          else add_result(srf_pkg::KIND_DONE_FAIL, 8'd0, 16'd0);
          phase_q = PH_IDLE;
        end
      end
      default: begin
        case (phase_q)
          PH_WAIT_ACK: begin
            if (b != srf_pkg::ACK_BYTE) begin
              add_result(srf_pkg::KIND_DONE_FAIL, 8'd0, 16'd0);
              phase_q = PH_IDLE;
            end else begin
              phase_q = (tx_left_q != 16'd0) ? PH_PAYLOAD : PH_RESP_ACK;
            end
          end
          PH_RESP_ACK: begin
            if (b != srf_pkg::ACK_BYTE) begin
              add_result(srf_pkg::KIND_DONE_FAIL, 8'd0, 16'd0);
              phase_q = PH_IDLE;
            end else begin
              phase_q = PH_LEN_LO;
            end
          end
          PH_LEN_LO: begin
            len_low_q = b;
            phase_q   = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            rlen = {b, len_low_q};
            if (rlen > resp_limit_q) rlen = resp_limit_q;
            resp_left_q  = rlen;
            resp_count_q = rlen;
            phase_q = (rlen != 16'd0) ? PH_DATA : PH_CHECK;
          end
          PH_DATA: begin
            add_result(srf_pkg::KIND_RESP_BYTE, b, 16'd0);
            resp_left_q = resp_left_q - 16'd1;
            if (resp_left_q == 16'd0) phase_q = PH_CHECK;
          end
          PH_CHECK: begin
            add_result(srf_pkg::KIND_DONE_OK, 8'd0, resp_count_q);
            phase_q = PH_IDLE;
          end
          default: rejected = 1'b1;
        endcase
      end
    endcase
    if (rejected) add_result(srf_pkg::KIND_REJECTED, 8'd0, 16'd0);
    if (pending_results.size() > first) begin
      pending_results[pending_results.size() - 1].last = 1'b1;
    end
  endfunction

  // Offer one item, hold it until the transfer, then update the tracker.
  task automatic send_item(input logic [1:0] op, input logic [7:0] ep, input logic [15:0] tl,
                           input logic [15:0] mr, input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    endpoint_i     <= ep;
    tx_length_i    <= tl;
    max_response_i <= mr;
    data_byte_i    <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    frame_item(op, ep, tl, mr, b);
  endtask

  // Mostly the next well-formed step of the current transaction, some noise.
  task automatic send_random_item();
    logic [1:0]  op;
    logic [7:0]  ep;
    logic [7:0]  b;
    logic [15:0] tl;
    logic [15:0] mr;
    op = srf_pkg::OP_RX_BYTE;
    ep = 8'($urandom);
    tl = 16'($urandom);
    mr = 16'($urandom);
    b  = 8'($urandom);
    if ($urandom_range(0, 99) < 10) begin
      op = 2'($urandom_range(0, 3));
    end else begin
      case (phase_q)
        PH_IDLE: begin
          op = srf_pkg::OP_START;
          if ($urandom_range(0, 4) != 0) tl = 16'($urandom_range(0, 5));
          case ($urandom_range(0, 2))
            0: mr = 16'($urandom_range(0, 6));
            1: mr = 16'hFFFF;
            default: ;
          endcase
        end
        PH_WAIT_ACK, PH_RESP_ACK: if ($urandom_range(0, 9) != 0) b = srf_pkg::ACK_BYTE;
        PH_PAYLOAD: begin
          // abort long payloads instead of streaming thousands of bytes
          if (tx_left_q > 16'd12 && $urandom_range(0, 3) == 0) op = srf_pkg::OP_TIMEOUT;
          else op = srf_pkg::OP_PAYLOAD;
        end
        PH_LEN_LO: if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(0, 6));
        PH_LEN_HI: if ($urandom_range(0, 3) != 0) b = 8'h00;
        PH_DATA: begin
          if (resp_left_q > 16'd12 && $urandom_range(0, 3) == 0) op = srf_pkg::OP_TIMEOUT;
        end
        default: if ($urandom_range(0, 3) == 0) op = srf_pkg::OP_TIMEOUT;
      endcase
    end
    send_item(op, ep, tl, mr, b);
  endtask

  task automatic test_header_extremes();
    send_item(srf_pkg::OP_START, 8'hFF, 16'h0000, 16'hFFFF, 8'h00);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, srf_pkg::ACK_BYTE);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, srf_pkg::ACK_BYTE);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'h00);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'h00);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'hFF);
    send_item(srf_pkg::OP_START, 8'h00, 16'hFFFF, 16'h0000, 8'hFF);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, srf_pkg::ACK_BYTE);
    send_item(srf_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 8'hFF);
    send_item(srf_pkg::OP_TIMEOUT, 8'h00, 16'h0000, 16'h0000, 8'h00);
  endtask

  task automatic test_out_of_phase();
    send_item(srf_pkg::OP_TIMEOUT, 8'h00, 16'h0000, 16'h0000, 8'h00);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, srf_pkg::ACK_BYTE);
    send_item(srf_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 8'h11);
    send_item(srf_pkg::OP_START, 8'h5A, 16'h0001, 16'h0002, 8'h00);
    send_item(srf_pkg::OP_START, 8'hA5, 16'h0003, 16'h0004, 8'h00);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, srf_pkg::ACK_BYTE);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, srf_pkg::ACK_BYTE);
    send_item(srf_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 8'h00);
    send_item(srf_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 8'h33);
  endtask

  task automatic test_clamp_and_failures();
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, srf_pkg::ACK_BYTE);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'h34);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'h12);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'hFF);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'h5A);
    send_item(srf_pkg::OP_TIMEOUT, 8'h00, 16'h0000, 16'h0000, 8'h00);
    send_item(srf_pkg::OP_START, 8'h81, 16'h0000, 16'h0000, 8'h00);
    send_item(srf_pkg::OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'h78);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall, input int items);
    src_idle_pct = idle_pct;
    stall_pct    = stall;
    repeat (items) send_random_item();
  endtask

  // Hold off the receiver while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    src_idle_pct = 0;
    stall_pct    = 0;
    stall_burst  = 400;
    repeat (60) send_random_item();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     <= 1'b0;
    opcode_i       <= srf_pkg::OP_START;
    endpoint_i     <= '0;
    tx_length_i    <= '0;
    max_response_i <= '0;
    data_byte_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_extremes();
    test_out_of_phase();
    test_clamp_and_failures();
    test_random_traffic(0, 0, 100);
    test_random_traffic(52, 0, 100);
    test_random_traffic(0, 52, 100);
    test_random_traffic(23, 23, 83);
    test_backpressure();
    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("serial_request_framer: match");
    end else begin
      $display("serial_request_framer: mismatch");
    end
    $finish;
  end

  initial begin : link_receiver
    int hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_burst != 0) begin
        hold_left   = stall_burst;
        stall_burst = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want != got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    link_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %h byte %h length %h last %b",
                 $time, out_kind_o, out_byte_o, resp_length_o, last_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("out_kind", 16'(want.kind), 16'(out_kind_o));
        compare_field("out_byte", 16'(want.byte_val), 16'(out_byte_o));
        compare_field("resp_length", want.length, resp_length_o);
        compare_field("last", 16'(want.last), 16'(last_o));
      end
    end
  end

  initial begin
    #2000000;
    $display("serial_request_framer: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/srf_pkg.sv
rtl/srf_front.sv
rtl/srf_queue.sv
rtl/srf_back.sv
rtl/serial_request_framer.sv
bench/serial_request_framer_test.sv
